/* rtl/rpv_pkg.sv */
// Shared types and constants for the running population variance block.
package rpv_pkg;

    localparam int ACC_W   = 128;
    localparam int DIV_W   = 33;
    localparam int PROD_W  = 64;
    localparam int COUNT_W = 17;
    localparam int SUM_W   = 48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ADD,
        S_FIN_START,
        S_FIN_MUL,
        S_FIN_ADD,
        S_DIV,
        S_OUT
    } t_state;

    // Partial products of the final pass, in the order they are taken.
    typedef enum logic [2:0] {
        STEP_NS0,
        STEP_NS1,
        STEP_NS2,
        STEP_SQ00,
        STEP_SQ01,
        STEP_SQ10,
        STEP_SQ11,
        STEP_NN
    } t_step;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/rpv_div.sv */
// Restoring divider, one quotient bit per cycle, 128-bit dividend by 33-bit divisor.
module rpv_div
    import rpv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ACC_W-1:0]   i_dividend,
    input  logic [DIV_W-1:0]   i_divisor,
    output logic [ACC_W-1:0]   o_quotient,
    output t_div_stat          o_stat
);

    localparam int CNT_W = $clog2(ACC_W);

    logic [ACC_W-1:0] r_num;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W+1:0] diff;
    logic             take;

    assign rem_sh = {r_rem, r_num[ACC_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_div};
    assign take   = ~diff[DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[ACC_W-2:0], take};
            r_rem <= take ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    assign o_quotient  = r_num;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* rtl/running_population_variance.sv */
// Top level: population variance of a stream of samples, one result per set.
//
// Samples arrive on the input channel (i_valid / o_ready) with i_last on the
// final sample of a set. Each accepted sample transfer is followed by a
// multiply state and an add state, in which one shared 32x32 multiplier
// squares it and one 128-bit adder folds it into the sum of squares; no new
// sample is taken until both are done. After the last sample the same
// multiplier and adder build n*S2 - S1^2 and n^2 step by step, and a
// bit-serial divider then divides the first by the second. With fewer than
// two samples these steps are skipped and the result has zero variance.
// The result (o_valid / i_ready) sits in an output register; once it is
// loaded the accumulators clear and the next set is taken while the result
// still waits. If the receiver stalls, the next set's result waits inside the
// block and no further sample is taken until the output register frees.
// Samples past MAX_SAMPLES are dropped and flagged in o_overflow.
// Reset (synchronous, active low) clears the accumulators and the output valid flag.
module running_population_variance
    import rpv_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536,
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_sample,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [62:0] o_variance_whole,
    output logic [15:0] o_variance_frac,
    output logic [16:0] o_sample_count,
    output logic        o_overflow
);

    localparam logic [31:0] SAMPLE_MASK = 32'((33'd1 << SAMPLE_BITS) - 33'd1);
    localparam logic [15:0] FRAC_MASK   = 16'((17'd1 << FRAC_BITS) - 17'd1);

    t_state r_state, n_state;
    t_step  r_step;

    logic [31:0]        r_x;
    logic               r_last;
    logic               r_taken;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [ACC_W-1:0]   r_ssq;
    logic [ACC_W-1:0]   r_acc;
    logic               r_drop;
    logic [PROD_W-1:0]  r_prod;
    logic               r_small;
    logic               r_ovalid;

    logic               in_xfer;
    logic               out_free;
    logic               room;
    logic [31:0]        x_in;
    logic [31:0]        mul_a, mul_b;
    logic [1:0]         shift_sel;
    logic               do_sub;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W-1:0]   add_base;
    logic [ACC_W-1:0]   add_res;
    logic               div_start;
    logic [ACC_W-1:0]   quotient;
    logic [ACC_W-1:0]   q_shr;
    t_div_stat          div_stat;

    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign room     = r_count < COUNT_W'(MAX_SAMPLES);
    assign x_in     = i_sample & SAMPLE_MASK;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (room) begin
                        n_state = S_SQ_MUL;
                    end else if (i_last) begin
                        n_state = S_FIN_START;
                    end
                end
            end
            S_SQ_MUL: n_state = S_SQ_ADD;
            S_SQ_ADD: n_state = r_last ? S_FIN_START : S_IDLE;
            S_FIN_START: n_state = (r_count < COUNT_W'(2)) ? S_OUT : S_FIN_MUL;
            S_FIN_MUL: n_state = S_FIN_ADD;
            S_FIN_ADD: n_state = (r_step == STEP_NN) ? S_DIV : S_FIN_MUL;
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier and adder.
    always_comb begin
        mul_a     = r_x;
        mul_b     = r_x;
        shift_sel = 2'd0;
        do_sub    = 1'b0;
        if (r_state == S_FIN_MUL || r_state == S_FIN_ADD) begin
            case (r_step)
                STEP_NS0: begin
                    mul_a = 32'(r_count);
                    mul_b = r_ssq[31:0];
                end
                STEP_NS1: begin
                    mul_a     = 32'(r_count);
                    mul_b     = r_ssq[63:32];
                    shift_sel = 2'd1;
                end
                STEP_NS2: begin
                    mul_a     = 32'(r_count);
                    mul_b     = r_ssq[95:64];
                    shift_sel = 2'd2;
                end
                STEP_SQ00: begin
                    mul_a  = r_sum[31:0];
                    mul_b  = r_sum[31:0];
                    do_sub = 1'b1;
                end
                STEP_SQ01: begin
                    mul_a     = r_sum[31:0];
                    mul_b     = 32'(r_sum[47:32]);
                    shift_sel = 2'd1;
                    do_sub    = 1'b1;
                end
                STEP_SQ10: begin
                    mul_a     = 32'(r_sum[47:32]);
                    mul_b     = r_sum[31:0];
                    shift_sel = 2'd1;
                    do_sub    = 1'b1;
                end
                STEP_SQ11: begin
                    mul_a     = 32'(r_sum[47:32]);
                    mul_b     = 32'(r_sum[47:32]);
                    shift_sel = 2'd2;
                    do_sub    = 1'b1;
                end
                STEP_NN: begin
                    mul_a = 32'(r_count);
                    mul_b = 32'(r_count);
                end
                default: begin
                    mul_a = r_x;
                    mul_b = r_x;
                end
            endcase
        end
    end

    assign addend    = ACC_W'(r_prod) << (7'(shift_sel) << 5);
    assign add_base  = (r_state == S_SQ_ADD) ? r_ssq : r_acc;
    assign add_res   = do_sub ? (add_base - addend) : (add_base + addend);
    assign div_start = (r_state == S_FIN_ADD) && (r_step == STEP_NN) && !div_stat.busy;

    rpv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc << FRAC_BITS),
        .i_divisor  (r_prod[DIV_W-1:0]),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    assign q_shr = quotient >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sum    <= '0;
            r_ssq    <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
            r_step   <= STEP_NS0;
        end else begin
            r_state <= n_state;
            // A new result may load in the same cycle the previous one transfers.
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (room) begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= r_sum + SUM_W'(x_in);
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                S_SQ_ADD: r_ssq <= add_res;
                S_FIN_START: r_step <= STEP_NS0;
                S_FIN_ADD: begin
                    if (r_step != STEP_NN) begin
                        r_step <= t_step'(r_step + 3'd1);
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_count  <= '0;
                        r_sum    <= '0;
                        r_ssq    <= '0;
                        r_drop   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x     <= x_in;
            r_last  <= i_last;
            r_taken <= room;
        end
        r_prod <= mul_a * mul_b;
        if (r_state == S_FIN_START) begin
            r_acc   <= '0;
            r_small <= r_count < COUNT_W'(2);
        end else if (r_state == S_FIN_ADD && r_step != STEP_NN) begin
            r_acc <= add_res;
        end
        if (r_state == S_OUT && out_free) begin
            o_sample_count <= r_count;
            o_overflow     <= r_drop || !r_taken;
            if (r_small) begin
                o_variance_whole <= '0;
                o_variance_frac  <= '0;
            end else begin
                o_variance_whole <= q_shr[62:0];
                o_variance_frac  <= (quotient[15:0] & FRAC_MASK) << (16 - FRAC_BITS);
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the running population variance block.
`timescale 1ns / 1ps

module tb_top;

    import rpv_pkg::COUNT_W;
    import rpv_pkg::SUM_W;

    localparam int MAX_SAMPLES = 65536;
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 32;
    localparam logic [31:0] SAMPLE_MASK = 32'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [62:0] whole;
        logic [15:0] frac;
        logic [16:0] sample_count;
        logic        overflow;
    } variance_result_t;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_SMALL,
        SPREAD_HIGH,
        SPREAD_NARROW,
        SPREAD_ONE_BIT
    } sample_style_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_sample = '0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [62:0] o_variance_whole;
    logic [15:0] o_variance_frac;
    logic [16:0] o_sample_count;
    logic        o_overflow;

    // Predictor state for the set being accumulated.
    logic [COUNT_W-1:0] held_count = '0;
    logic [SUM_W-1:0]   held_sum = '0;
    logic [127:0]       held_square_sum = '0;
    logic               held_dropped = 1'b0;

    variance_result_t expected_variance[$];

    int  error_count = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    int  burst_left = 0;
    int  ready_left = 0;
    bit  ready_phase = 1'b1;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;

    running_population_variance #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .FRAC_BITS  (FRAC_BITS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_variance_whole(o_variance_whole),
        .o_variance_frac (o_variance_frac),
        .o_sample_count  (o_sample_count),
        .o_overflow      (o_overflow)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 40) begin
            $display("mismatch in %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
        end
    endtask

    // Folds one accepted sample into the predicted set; closes the set on last.
    function automatic void accumulate_sample(input logic [31:0] value, input logic is_last);
        logic [31:0]      x;
        logic [127:0]     n_s2;
        logic [127:0]     s1_sq;
        logic [127:0]     scaled;
        logic [127:0]     quotient;
        variance_result_t res;
        x = value & SAMPLE_MASK;
        if (held_count < MAX_SAMPLES) begin
            held_count = held_count + 1'b1;
            held_sum = held_sum + x;
            held_square_sum = held_square_sum + 128'(x) * 128'(x);
        end else begin
            held_dropped = 1'b1;
        end
        if (is_last) begin
            res = '0;
            if (held_count >= 2) begin
                n_s2 = 128'(held_count) * held_square_sum;
                s1_sq = 128'(held_sum) * 128'(held_sum);
                scaled = (n_s2 - s1_sq) << FRAC_BITS;
                quotient = scaled / (128'(held_count) * 128'(held_count));
                res.whole = 63'(quotient >> FRAC_BITS);
                res.frac = 16'((quotient & ((128'd1 << FRAC_BITS) - 128'd1))
                               << (16 - FRAC_BITS));
            end
            res.sample_count = held_count;
            res.overflow = held_dropped;
            expected_variance.push_back(res);
            held_count = '0;
            held_sum = '0;
            held_square_sum = '0;
            held_dropped = 1'b0;
        end
    endfunction

    // Presents one sample and returns at the edge where it transfers.
    task automatic send_sample(input logic [31:0] value, input logic is_last);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            i_sample <= $urandom;
            i_last <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        i_valid <= 1'b1;
        i_sample <= value;
        i_last <= is_last;
        do @(posedge i_clk); while (!o_ready);
        accumulate_sample(value, is_last);
    endtask

    function automatic logic [31:0] pick_sample(input sample_style_t style,
                                                input logic [31:0] base);
        case (style)
            SPREAD_SMALL:   return 32'($urandom_range(0, 255));
            SPREAD_HIGH:    return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
            SPREAD_NARROW:  return base ^ 32'($urandom_range(0, 15));
            SPREAD_ONE_BIT: return 32'd1 << $urandom_range(0, 31);
            default:        return $urandom;
        endcase
    endfunction

    // Receiver: alternating runs of ready and stall of random length.
    always @(posedge i_clk) begin
        if (!stalls_on) begin
            i_ready <= 1'b1;
        end else if (ready_left == 0) begin
            ready_phase = !ready_phase;
            ready_left = ready_phase ? $urandom_range(1, 20) : $urandom_range(1, 40);
            i_ready <= ready_phase;
        end else begin
            ready_left--;
        end
    end

    always @(posedge i_clk) begin
        variance_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_variance.size() == 0) begin
                report_mismatch("result with no set closed", 64'(o_sample_count), 64'd0);
            end else begin
                want = expected_variance.pop_front();
                if (o_variance_whole !== want.whole)
                    report_mismatch("variance_whole", 64'(o_variance_whole), 64'(want.whole));
                if (o_variance_frac !== want.frac)
                    report_mismatch("variance_frac", 64'(o_variance_frac), 64'(want.frac));
                if (o_sample_count !== want.sample_count)
                    report_mismatch("sample_count", 64'(o_sample_count),
                                    64'(want.sample_count));
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", 64'(o_overflow), 64'(want.overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Short sets at the edges of the value range and with known fractions.
    task automatic test_directed_sets();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        send_sample(32'd0, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'd0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        repeat (3) send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'hAAAA_AAAA, 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b1);
        send_sample(32'd1, 1'b0);
        send_sample(32'd2, 1'b1);
        send_sample(32'd1, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'd2, 1'b1);
        send_sample(32'd7, 1'b0);
        send_sample(32'd7, 1'b1);
        repeat (3) send_sample(32'd0, 1'b0);
        send_sample(32'd1, 1'b1);
    endtask

    task automatic test_random_sets(input int n_items, input bit use_gaps,
                                    input bit use_stalls);
        int            sent;
        int            set_len;
        sample_style_t style;
        logic [31:0]   base;
        gaps_on = use_gaps;
        stalls_on = use_stalls;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0:       set_len = 1;
                8:       set_len = $urandom_range(13, 64);
                9:       set_len = $urandom_range(65, 160);
                default: set_len = $urandom_range(2, 12);
            endcase
            style = sample_style_t'($urandom_range(0, 4));
            base = $urandom;
            for (int k = 0; k < set_len; k++) begin
                send_sample(pick_sample(style, base), k == set_len - 1);
            end
            sent += set_len;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sets();
        test_random_sets(650, 1'b1, 1'b1);
        test_random_sets(350, 1'b0, 1'b0);
        i_valid <= 1'b0;
        while (expected_variance.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_variance.size() != 0)
            report_mismatch("results still owed", 64'(expected_variance.size()), 64'd0);
        if (error_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/rpv_pkg.sv
rtl/rpv_div.sv
rtl/running_population_variance.sv
tb/sv/tb_top.sv
